// ----- src/edf_pkg.sv -----
// Shared types, command codes and default sizes for the EDF tick scheduler.
package edf_pkg;

  localparam int MAX_TASKS_DEF  = 16;
  localparam int PARAM_BITS_DEF = 16;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  task_index;
    logic [15:0] exec_budget;
    logic [15:0] task_period;
    logic [15:0] relative_deadline;
  } in_item_t;

  typedef struct packed {
    logic        tick_done;
    logic        busy_res;
    logic [4:0]  running_id;
    logic [31:0] tick_time;
  } out_item_t;

  typedef struct packed {
    logic       clr_we;
    logic       load_we;
    logic       rd_en;
    logic       rd_restart;
    logic       search_clr;
    logic       fin;
    logic [1:0] fin_cmd;
  } ctl_t;

endpackage

// ----- src/edf_ctrl.sv -----
// Sequencer for the EDF scheduler: clearing pass, slot sweeps and result timing.
module edf_ctrl #(
  parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF,
  localparam int IDX_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [1:0]               cmd,
  input  logic [3:0]               task_index,
  input  logic [4:0]               task_count,
  output logic                     busy,
  output logic [IDX_W-1:0]         idx_o,
  output edf_pkg::ctl_t            ctl_o
);

  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_TASKS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  logic [CNT_W-1:0] n_act;
  logic [IDX_W-1:0] last_idx;
  logic             slot_ok;

  always_comb begin
    if (32'(task_count) > 32'(MAX_TASKS)) begin
      n_act = CNT_W'(MAX_TASKS);
    end else begin
      n_act = CNT_W'(task_count);
    end
  end

  assign last_idx = (cmd_r == edf_pkg::CMD_RESTART) ? LAST_SLOT : IDX_W'(n_act - 1'b1);
  assign slot_ok  = 32'(task_index) < 32'(MAX_TASKS);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd_nxt   = cmd_r;
    ctl_o     = '0;
    unique case (state_r)
      S_CLEAR: begin
        ctl_o.clr_we = 1'b1;
        if (idx_r == LAST_SLOT) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_nxt = cmd;
          idx_nxt = '0;
          unique case (cmd)
            edf_pkg::CMD_LOAD: begin
              ctl_o.load_we = slot_ok;
              state_nxt     = S_FIN;
            end
            edf_pkg::CMD_RESTART: begin
              state_nxt = S_SWEEP;
            end
            edf_pkg::CMD_TICK: begin
              ctl_o.search_clr = 1'b1;
              state_nxt        = (n_act == '0) ? S_FIN : S_SWEEP;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_SWEEP: begin
        ctl_o.rd_en      = 1'b1;
        ctl_o.rd_restart = (cmd_r == edf_pkg::CMD_RESTART);
        if (idx_r == last_idx) begin
          idx_nxt   = '0;
          state_nxt = S_WAIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_WAIT: begin
        // let the last slot's write-back land
        state_nxt = S_FIN;
      end
      S_FIN: begin
        ctl_o.fin     = 1'b1;
        ctl_o.fin_cmd = cmd_r;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r   <= '0;
      cmd_r   <= edf_pkg::CMD_LOAD;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  assign busy  = (state_r != S_IDLE);
  assign idx_o = idx_r;

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_o.load_we |-> (state_r == S_IDLE && start))
    else $error("load write outside an accepted transfer");

  a_fin_single: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_o.fin |=> !ctl_o.fin && state_r == S_IDLE)
    else $error("result strobe longer than one cycle");

  a_clr_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_o.clr_we |-> !ctl_o.rd_en && !ctl_o.fin && busy)
    else $error("clearing pass overlaps other work");

endmodule

// ----- src/edf_dpath.sv -----
// Task tables, release and deadline update, minimum-deadline search and result register.
module edf_dpath #(
  parameter int MAX_TASKS  = edf_pkg::MAX_TASKS_DEF,
  parameter int PARAM_BITS = edf_pkg::PARAM_BITS_DEF,
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  edf_pkg::ctl_t        ctl_i,
  input  logic [IDX_W-1:0]     idx_i,
  input  edf_pkg::in_item_t    in_item,
  output logic                 out_valid,
  output edf_pkg::out_item_t   out_item
);

  logic [PARAM_BITS-1:0] bud_mem [MAX_TASKS];
  logic [PARAM_BITS-1:0] per_mem [MAX_TASKS];
  logic [PARAM_BITS-1:0] dl_mem  [MAX_TASKS];
  logic [PARAM_BITS-1:0] rem_mem [MAX_TASKS];
  logic [31:0]           rel_mem [MAX_TASKS];
  logic [31:0]           abs_mem [MAX_TASKS];

  logic [PARAM_BITS-1:0] bud_rd_r, per_rd_r, dl_rd_r, rem_rd_r;
  logic [31:0]           rel_rd_r, abs_rd_r;

  logic                  s2_v_r, s2_rst_r;
  logic [IDX_W-1:0]      s2_idx_r;

  logic [31:0]           now_r;
  logic                  best_found_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [31:0]           best_abs_r;
  logic [PARAM_BITS-1:0] best_rem_r;

  logic                  out_valid_r;
  edf_pkg::out_item_t    out_item_r, out_item_nxt;

  logic                  hit, better, fin_tick;
  logic [PARAM_BITS-1:0] new_rem;
  logic [31:0]           new_rel, new_abs;

  logic                  rem_we, tab_we, par_we;
  logic [IDX_W-1:0]      rem_wa, tab_wa, par_wa;
  logic [PARAM_BITS-1:0] rem_wd, bud_wd, per_wd, dl_wd;
  logic [31:0]           rel_wd, abs_wd;

  // Write-back stage: reset the slot on restart, else release it if due, then weigh it against the best so far
  always_comb begin
    hit = !s2_rst_r && (rel_rd_r == now_r);
    if (s2_rst_r) begin
      new_rem = '0;
      new_rel = '0;
      new_abs = 32'(dl_rd_r);
    end else if (hit) begin
      new_rem = bud_rd_r;
      new_rel = rel_rd_r + 32'(per_rd_r);
      new_abs = now_r + 32'(dl_rd_r);
    end else begin
      new_rem = rem_rd_r;
      new_rel = rel_rd_r;
      new_abs = abs_rd_r;
    end
    better = s2_v_r && !s2_rst_r && (new_rem != '0) &&
             (!best_found_r || (new_abs < best_abs_r));
  end

  assign fin_tick = ctl_i.fin && (ctl_i.fin_cmd == edf_pkg::CMD_TICK);

  always_comb begin
    rem_we = ctl_i.clr_we || s2_v_r || (fin_tick && best_found_r);
    if (ctl_i.clr_we) begin
      rem_wa = idx_i;
      rem_wd = '0;
    end else if (s2_v_r) begin
      rem_wa = s2_idx_r;
      rem_wd = new_rem;
    end else begin
      rem_wa = best_idx_r;
      rem_wd = best_rem_r - 1'b1;
    end

    tab_we = ctl_i.clr_we || s2_v_r;
    tab_wa = ctl_i.clr_we ? idx_i : s2_idx_r;
    rel_wd = ctl_i.clr_we ? '0 : new_rel;
    abs_wd = ctl_i.clr_we ? '0 : new_abs;

    par_we = ctl_i.clr_we || ctl_i.load_we;
    par_wa = ctl_i.clr_we ? idx_i : IDX_W'(in_item.task_index);
    bud_wd = ctl_i.clr_we ? '0 : PARAM_BITS'(in_item.exec_budget);
    per_wd = ctl_i.clr_we ? '0 : PARAM_BITS'(in_item.task_period);
    dl_wd  = ctl_i.clr_we ? '0 : PARAM_BITS'(in_item.relative_deadline);
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      bud_mem[par_wa] <= bud_wd;
      per_mem[par_wa] <= per_wd;
      dl_mem[par_wa]  <= dl_wd;
    end
    if (ctl_i.rd_en) begin
      bud_rd_r <= bud_mem[idx_i];
      per_rd_r <= per_mem[idx_i];
      dl_rd_r  <= dl_mem[idx_i];
    end
  end

  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    if (ctl_i.rd_en) begin
      rem_rd_r <= rem_mem[idx_i];
    end
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      rel_mem[tab_wa] <= rel_wd;
      abs_mem[tab_wa] <= abs_wd;
    end
    if (ctl_i.rd_en) begin
      rel_rd_r <= rel_mem[idx_i];
      abs_rd_r <= abs_mem[idx_i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r   <= 1'b0;
      s2_rst_r <= 1'b0;
    end else begin
      s2_v_r   <= ctl_i.rd_en;
      s2_rst_r <= ctl_i.rd_restart;
    end
    s2_idx_r <= idx_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
    end else if (ctl_i.search_clr) begin
      best_found_r <= 1'b0;
    end else if (better) begin
      best_found_r <= 1'b1;
    end
    if (better) begin
      best_idx_r <= s2_idx_r;
      best_abs_r <= new_abs;
      best_rem_r <= new_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0;
    end else if (ctl_i.fin && ctl_i.fin_cmd == edf_pkg::CMD_RESTART) begin
      now_r <= '0;
    end else if (fin_tick) begin
      now_r <= now_r + 32'd1;
    end
  end

  always_comb begin
    out_item_nxt = '0;
    if (fin_tick) begin
      out_item_nxt.tick_done = 1'b1;
      out_item_nxt.busy_res  = best_found_r;
      out_item_nxt.tick_time = now_r;
      if (best_found_r) begin
        out_item_nxt.running_id = 5'({1'b0, best_idx_r} + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_i.fin;
    end
    if (ctl_i.fin) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_fin_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_i.fin |-> !s2_v_r && !ctl_i.rd_en)
    else $error("result taken before sweep write-back drained");

endmodule

// ----- src/edf_periodic_task_scheduler.sv -----
// Top level of the earliest-deadline-first periodic task scheduler.
//
//  channel  ports                                       transfer
//  input    start, busy, in_item                        start && !busy
//  result   out_valid, out_item                         out_valid, one cycle
//  config   psel, penable, pwrite, paddr, pwdata,       psel && penable && pwrite
//           prdata, pready
//
// Tick: a sweep reads slots 0 to n - 1, n the active task count,
//   and is skipped when no slot is active;
//   one table slot is read per cycle through the single read port of the task tables.
// Restart: every slot is rewritten. Load and unused codes go straight to the result.
// After reset a clearing pass zeroes the tables with busy high.
// The result appears on out_valid for one cycle; the receiver cannot stall it.
module edf_periodic_task_scheduler #(
  parameter int MAX_TASKS  = edf_pkg::MAX_TASKS_DEF,
  parameter int PARAM_BITS = edf_pkg::PARAM_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  edf_pkg::in_item_t  in_item,
  output logic               out_valid,
  output edf_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  logic [4:0]       task_count_r;
  logic [IDX_W-1:0] idx;
  edf_pkg::ctl_t    ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      task_count_r <= pwdata[4:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {27'd0, task_count_r};

  edf_ctrl #(
    .MAX_TASKS(MAX_TASKS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd       (in_item.cmd),
    .task_index(in_item.task_index),
    .task_count(task_count_r),
    .busy      (busy),
    .idx_o     (idx),
    .ctl_o     (ctl)
  );

  edf_dpath #(
    .MAX_TASKS (MAX_TASKS),
    .PARAM_BITS(PARAM_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (ctl),
    .idx_i    (idx),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule
